>>> rtl/core/pftc_pkg.sv
package pftc_pkg;

    localparam int FLOW_ENTRIES = 256;
    localparam int SLOT_BITS    = $clog2(FLOW_ENTRIES);
    localparam int USED_BITS    = SLOT_BITS + 1;
    localparam int COUNT_BITS   = 32;
    localparam int KEY_BITS     = 64 + 32 + 3;

    localparam logic [15:0] TPID_VLAN      = 16'h8100;
    localparam logic [7:0]  PROTO_NUM_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_NUM_IGMP = 8'd2;
    localparam logic [6:0]  POS_MAX        = 7'd127;

    localparam logic [2:0] CLASS_OTHER = 3'd0;
    localparam logic [2:0] CLASS_UDP   = 3'd1;
    localparam logic [2:0] CLASS_TCP   = 3'd2;
    localparam logic [2:0] CLASS_ICMP  = 3'd3;
    localparam logic [2:0] CLASS_IGMP  = 3'd4;

    localparam logic [1:0] STATUS_COUNTED = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    typedef enum logic [2:0] {
        ST_PARSE,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Tuple captured from one packet, handed from parser to lookup.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [2:0]  proto;
        logic        bad;
    } tuple_t;

    function automatic logic [2:0] class_of(input logic [7:0] p);
        logic [2:0] c;
        c = CLASS_OTHER;
        if (p == PROTO_NUM_UDP) c = CLASS_UDP;
        else if (p == PROTO_NUM_TCP) c = CLASS_TCP;
        else if (p == PROTO_NUM_ICMP) c = CLASS_ICMP;
        else if (p == PROTO_NUM_IGMP) c = CLASS_IGMP;
        return c;
    endfunction

endpackage

>>> rtl/core/packet_flow_tuple_counter_core.sv
// Five-tuple flow counter. Packet bytes stream in on s_axis, one per beat,
// starting at the Ethernet header; tlast marks the final byte. Each packet
// yields one result beat on m_axis with its addresses, ports, protocol
// class, table slot, saturating packet count and status. Ordinary bytes
// are taken while the block parses; at the last byte input goes not ready
// until the result beat is taken. A good packet makes the block walk its
// flow table, one synchronous memory with a registered read, one entry at
// a time (read, then compare) over the entries in use, then write the new
// or incremented entry back unless the table is full; a bad packet skips
// the walk. After reset the table is empty and needs no clearing pass.
module packet_flow_tuple_counter_core
    import pftc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // packet_byte
    input  logic          s_axis_tlast,   // last_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // source_ip, dest_ip, source_port_out, dest_port_out, protocol_kind,
    // flow_slot, packet_total, first_of_flow, status (lowest bit first)
    output logic [143:0]  m_axis_tdata
);

    state_t state_reg, state_next;
    tuple_t tuple_w;
    tuple_t tup_reg;

    logic [USED_BITS-1:0]  used_reg;
    logic [USED_BITS-1:0]  idx_reg, idx_next;
    logic                  beat_en;

    // table: key (addresses, ports, class) and count per entry
    logic [KEY_BITS+COUNT_BITS-1:0] tbl_mem [FLOW_ENTRIES];
    logic [KEY_BITS+COUNT_BITS-1:0] rd_reg;
    logic                           wr_en;
    logic [SLOT_BITS-1:0]           wr_addr;
    logic [KEY_BITS+COUNT_BITS-1:0] wr_data;

    logic [KEY_BITS-1:0]   key;
    logic                  hit;
    logic [COUNT_BITS-1:0] cnt_inc;

    logic                  ov_reg;
    logic                  res_hit_reg;
    logic [SLOT_BITS-1:0]  res_slot_reg;
    logic [COUNT_BITS-1:0] res_cnt_reg;
    logic [1:0]            res_status_reg;
    logic                  res_first_reg;

    assign beat_en = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_PARSE);

    pftc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_en  (beat_en),
        .pkt_byte (s_axis_tdata),
        .pkt_last (s_axis_tlast),
        .tuple    (tuple_w)
    );

    assign key     = {tup_reg.src_ip, tup_reg.dst_ip, tup_reg.src_port,
                      tup_reg.dst_port, tup_reg.proto};
    assign hit     = (rd_reg[KEY_BITS+COUNT_BITS-1:COUNT_BITS] == key);
    assign cnt_inc = (rd_reg[COUNT_BITS-1:0] == '1) ? rd_reg[COUNT_BITS-1:0]
                                                    : rd_reg[COUNT_BITS-1:0] + 1'b1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[SLOT_BITS-1:0];
        wr_data    = {key, cnt_inc};
        case (state_reg)
            ST_PARSE: begin
                if (beat_en && s_axis_tlast) begin
                    idx_next = '0;
                    state_next = tuple_w.bad ? ST_OUT : ST_READ;
                end
            end
            ST_READ: begin
                // walk done without a hit: insert or flag full
                state_next = (idx_reg == used_reg) ? ST_WRITE : ST_CMP;
            end
            ST_CMP: begin
                if (hit) begin
                    state_next = ST_WRITE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_WRITE: begin
                if (res_hit_reg) begin
                    wr_en = 1'b1;
                end else if (!ov_reg) begin
                    wr_en   = 1'b1;
                    wr_data = {key, {{(COUNT_BITS-1){1'b0}}, 1'b1}};
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) state_next = ST_PARSE;
            end
            default: state_next = ST_PARSE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) tbl_mem[wr_addr] <= wr_data;
        rd_reg <= tbl_mem[idx_reg[SLOT_BITS-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PARSE;
            used_reg  <= '0;
            idx_reg   <= '0;
            res_hit_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == ST_PARSE && beat_en && s_axis_tlast) res_hit_reg <= 1'b0;
            if (state_reg == ST_CMP && hit) res_hit_reg <= 1'b1;
            if (state_reg == ST_WRITE && !res_hit_reg && !ov_reg)
                used_reg <= used_reg + 1'b1;
        end
    end

    // payload and result registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PARSE && beat_en && s_axis_tlast) begin
            tup_reg        <= tuple_w;
            ov_reg         <= (used_reg == USED_BITS'(FLOW_ENTRIES));
            res_slot_reg   <= '0;
            res_cnt_reg    <= '0;
            res_first_reg  <= 1'b0;
            res_status_reg <= tuple_w.bad ? STATUS_BAD : STATUS_COUNTED;
        end
        if (state_reg == ST_WRITE) begin
            res_slot_reg <= idx_reg[SLOT_BITS-1:0];
            if (res_hit_reg) begin
                res_cnt_reg <= cnt_inc;
            end else if (!ov_reg) begin
                res_cnt_reg   <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
                res_first_reg <= 1'b1;
            end else begin
                res_slot_reg   <= '0;
                res_status_reg <= STATUS_FULL;
            end
        end
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {2'd0, res_status_reg, res_first_reg, res_cnt_reg,
                            res_slot_reg[7:0], tup_reg.proto, tup_reg.dst_port,
                            tup_reg.src_port, tup_reg.dst_ip, tup_reg.src_ip};

endmodule

>>> rtl/core/pftc_parser.sv
module pftc_parser
    import pftc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_en,
    input  logic [7:0]   pkt_byte,
    input  logic         pkt_last,
    output tuple_t       tuple
);

    logic [6:0]  pos_reg;
    logic [7:0]  type_hi_reg;
    logic        vlan_reg;
    logic [3:0]  ihl_reg;
    logic [2:0]  proto_reg;
    logic [31:0] sip_reg, dip_reg;
    logic [15:0] sport_reg, dport_reg;

    logic [6:0]  base;
    logic        in_ip;
    logic [6:0]  off;
    logic [6:0]  port_at;
    logic        ihl_ok;
    logic [3:0]  ihl_n;
    logic [2:0]  proto_n;
    logic [31:0] sip_n, dip_n;
    logic [15:0] sport_n, dport_n;
    logic        has_ports;
    logic [7:0]  need;
    logic [7:0]  need_ports;

    always_comb begin
        base    = vlan_reg ? 7'd18 : 7'd14;
        in_ip   = (pos_reg >= 7'd14) && (pos_reg >= base);
        off     = pos_reg - base;
        port_at = {1'b0, ihl_reg, 2'b00};
        ihl_ok  = ihl_reg >= 4'd5;
        ihl_n   = ihl_reg;
        proto_n = proto_reg;
        sip_n   = sip_reg;
        dip_n   = dip_reg;
        sport_n = sport_reg;
        dport_n = dport_reg;
        if (in_ip) begin
            if (off == 7'd0) begin
                ihl_n = pkt_byte[3:0];
            end else if (off == 7'd9) begin
                proto_n = class_of(pkt_byte);
            end else if (off >= 7'd12 && off <= 7'd15) begin
                sip_n = {sip_reg[23:0], pkt_byte};
            end else if (off >= 7'd16 && off <= 7'd19) begin
                dip_n = {dip_reg[23:0], pkt_byte};
            end
            // port window uses the header length held before this beat
            if (ihl_ok && off >= port_at && off < port_at + 7'd2) begin
                sport_n = {sport_reg[7:0], pkt_byte};
            end else if (ihl_ok && off >= port_at + 7'd2 && off < port_at + 7'd4) begin
                dport_n = {dport_reg[7:0], pkt_byte};
            end
        end
        has_ports  = (proto_n == CLASS_UDP) || (proto_n == CLASS_TCP);
        need       = {1'b0, base} + 8'd20;
        need_ports = {1'b0, base} + {2'b00, ihl_n, 2'b00} + 8'd4;
        if (has_ports && need_ports > need) need = need_ports;
        tuple.src_ip   = sip_n;
        tuple.dst_ip   = dip_n;
        tuple.src_port = has_ports ? sport_n : 16'd0;
        tuple.dst_port = has_ports ? dport_n : 16'd0;
        tuple.proto    = proto_n;
        tuple.bad      = (ihl_n < 4'd5) || ({1'b0, pos_reg} + 8'd1 < need);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; type_hi_reg <= '0; vlan_reg <= 1'b0; ihl_reg <= '0;
            proto_reg <= '0; sip_reg <= '0; dip_reg <= '0;
            sport_reg <= '0; dport_reg <= '0;
        end else if (beat_en) begin
            if (pkt_last) begin
                pos_reg <= '0; type_hi_reg <= '0; vlan_reg <= 1'b0; ihl_reg <= '0;
                proto_reg <= '0; sip_reg <= '0; dip_reg <= '0;
                sport_reg <= '0; dport_reg <= '0;
            end else begin
                pos_reg <= (pos_reg < POS_MAX) ? pos_reg + 7'd1 : POS_MAX;
                if (pos_reg == 7'd12) type_hi_reg <= pkt_byte;
                if (pos_reg == 7'd13) vlan_reg <= ({type_hi_reg, pkt_byte} == TPID_VLAN);
                ihl_reg   <= ihl_n;
                proto_reg <= proto_n;
                sip_reg   <= sip_n;
                dip_reg   <= dip_n;
                sport_reg <= sport_n;
                dport_reg <= dport_n;
            end
        end
    end

endmodule

>>> rtl/core/pftc_checker.sv
module pftc_checker
    import pftc_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // no input taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // a last beat closes the input side for the lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open right after last beat");

    // status is never the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[141:140] <= STATUS_BAD)
        else $error("bad status code");

    // a new flow reports a total of one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[139] |-> m_axis_tdata[138:107] == 32'd1)
        else $error("new flow without count of one");

endmodule

bind packet_flow_tuple_counter_core pftc_checker u_pftc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/packet_flow_tuple_counter_core_tb.sv
`default_nettype none

// Drives packets byte by byte into the flow counter and checks every
// result beat against a cycle-free model of the parser and the flow table.
module packet_flow_tuple_counter_core_tb;
    import pftc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    always #2 aclk = ~aclk;

    packet_flow_tuple_counter_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // One flow report as it leaves the block.
    typedef struct {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic [31:0] total;
        logic        first;
        logic [1:0]  status;
    } flow_report_t;

    // A five-tuple plus the raw protocol byte used to build packets.
    typedef struct {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_tuple_t;

    flow_report_t pending_reports[$];
    int           error_count = 0;
    int           bytes_sent = 0;

    // Parser state of the model.
    logic [6:0]  pos;
    logic [7:0]  type_hi;
    logic        vlan;
    logic [3:0]  ihl;
    logic [2:0]  cls;
    logic [31:0] cap_sip;
    logic [31:0] cap_dip;
    logic [15:0] cap_sport;
    logic [15:0] cap_dport;

    // Flow table of the model.
    logic [63:0] tab_addr [FLOW_ENTRIES];
    logic [31:0] tab_ports[FLOW_ENTRIES];
    logic [2:0]  tab_cls  [FLOW_ENTRIES];
    logic [31:0] tab_cnt  [FLOW_ENTRIES];
    int          flows_used;

    flow_tuple_t  pool[16];
    logic [7:0]   pkt_bytes[$];
    flow_report_t last_report;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [2:0] classify(input logic [7:0] p);
        case (p)
            PROTO_NUM_UDP:  return CLASS_UDP;
            PROTO_NUM_TCP:  return CLASS_TCP;
            PROTO_NUM_ICMP: return CLASS_ICMP;
            PROTO_NUM_IGMP: return CLASS_IGMP;
            default:        return CLASS_OTHER;
        endcase
    endfunction

    task automatic clear_parser();
        pos = '0; type_hi = '0; vlan = 1'b0; ihl = '0; cls = CLASS_OTHER;
        cap_sip = '0; cap_dip = '0; cap_sport = '0; cap_dport = '0;
    endtask

    // Advance the parser by one accepted byte; on the last byte resolve
    // the tuple against the table and queue the expected report.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int           idx, base, off, port_at, need, hit;
        logic         ports_ok, bad;
        logic [63:0]  addr;
        logic [31:0]  ports;
        flow_report_t r;
        idx = int'(pos);
        if (idx == 12) type_hi = b;
        if (idx == 13) vlan = ({type_hi, b} == TPID_VLAN);
        base = vlan ? 18 : 14;
        if (idx >= 14 && idx >= base) begin
            off = idx - base;
            if (off == 0) ihl = b[3:0];
            else if (off == 9) cls = classify(b);
            else if (off >= 12 && off <= 15) cap_sip = {cap_sip[23:0], b};
            else if (off >= 16 && off <= 19) cap_dip = {cap_dip[23:0], b};
            port_at = ihl * 4;
            if (ihl >= 5 && off >= port_at && off < port_at + 2)
                cap_sport = {cap_sport[7:0], b};
            else if (ihl >= 5 && off >= port_at + 2 && off < port_at + 4)
                cap_dport = {cap_dport[7:0], b};
        end
        pos = (idx < POS_MAX) ? 7'(idx + 1) : POS_MAX;
        if (!last) return;

        ports_ok = (cls == CLASS_UDP || cls == CLASS_TCP);
        need = base + 20;
        if (ports_ok && base + ihl * 4 + 4 > need) need = base + ihl * 4 + 4;
        bad = (ihl < 5) || (idx + 1 < need);
        r.sip = cap_sip; r.dip = cap_dip;
        r.sport = ports_ok ? cap_sport : 16'h0;
        r.dport = ports_ok ? cap_dport : 16'h0;
        r.kind = cls; r.slot = '0; r.total = '0; r.first = 1'b0;
        r.status = STATUS_COUNTED;
        if (bad) begin
            r.status = STATUS_BAD;
        end else begin
            addr = {cap_sip, cap_dip};
            ports = {r.sport, r.dport};
            hit = -1;
            for (int i = 0; i < flows_used; i++)
                if (hit < 0 && tab_addr[i] == addr && tab_ports[i] == ports
                    && tab_cls[i] == cls) hit = i;
            if (hit >= 0) begin
                if (tab_cnt[hit] != 32'hFFFF_FFFF) tab_cnt[hit]++;
                r.slot = hit[7:0]; r.total = tab_cnt[hit];
            end else if (flows_used < FLOW_ENTRIES) begin
                tab_addr[flows_used] = addr; tab_ports[flows_used] = ports;
                tab_cls[flows_used] = cls; tab_cnt[flows_used] = 1;
                r.slot = flows_used[7:0]; r.total = 1; r.first = 1'b1;
                flows_used++;
            end else begin
                r.status = STATUS_FULL;
            end
        end
        pending_reports.push_back(r);
        last_report = r;
        clear_parser();
    endtask

    function automatic flow_tuple_t random_tuple(input logic [7:0] proto);
        flow_tuple_t t;
        t.sip = $urandom; t.dip = $urandom;
        t.sport = 16'($urandom); t.dport = 16'($urandom); t.proto = proto;
        return t;
    endfunction

    function automatic int min_length(input logic tag, input int hl, input logic [7:0] p);
        int base, n;
        base = tag ? 18 : 14;
        n = base + 20;
        if ((classify(p) == CLASS_UDP || classify(p) == CLASS_TCP) && base + hl * 4 + 4 > n)
            n = base + hl * 4 + 4;
        return n;
    endfunction

    // Fill pkt_bytes with random content and lay the header fields over it.
    task automatic build_packet(input logic tag, input logic [15:0] etype,
                                input logic [3:0] hl, input flow_tuple_t t, input int len);
        int base, pa;
        pkt_bytes.delete();
        for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
        base = tag ? 18 : 14;
        pa = base + hl * 4;
        if (len > 12) pkt_bytes[12] = tag ? TPID_VLAN[15:8] : etype[15:8];
        if (len > 13) pkt_bytes[13] = tag ? TPID_VLAN[7:0] : etype[7:0];
        if (len > base) pkt_bytes[base] = {4'h4, hl};
        if (len > base + 9) pkt_bytes[base + 9] = t.proto;
        for (int k = 0; k < 4; k++) begin
            if (len > base + 12 + k) pkt_bytes[base + 12 + k] = t.sip[31 - 8*k -: 8];
            if (len > base + 16 + k) pkt_bytes[base + 16 + k] = t.dip[31 - 8*k -: 8];
        end
        if (hl >= 5) begin
            for (int k = 0; k < 2; k++) begin
                if (len > pa + k)     pkt_bytes[pa + k]     = t.sport[15 - 8*k -: 8];
                if (len > pa + 2 + k) pkt_bytes[pa + 2 + k] = t.dport[15 - 8*k -: 8];
            end
        end
    endtask

    // Push pkt_bytes through the input channel; sometimes burst with no gaps.
    // Drop valid after the last byte so it is never taken twice.
    task automatic send_packet();
        int   gap;
        logic calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pkt_bytes[i];
            s_axis_tlast  <= (i == pkt_bytes.size() - 1);
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            absorb_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
            bytes_sent++;
            gap = calm ? 0 : $urandom_range(0, 15);
            if (i == pkt_bytes.size() - 1 && gap == 0) gap = 1;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Directed packets: each special case once, with the obvious results typed in.
    typedef struct {
        logic        tag;
        logic [3:0]  hl;
        logic [7:0]  proto;
        int          flow;
        int          len;
        logic        typed;
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] total;
        logic        first;
    } packet_row_t;

    localparam int ROWS = 16;
    packet_row_t rows[ROWS] = '{
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  0, 60,  1'b1, STATUS_COUNTED, 8'd0, 32'd1, 1'b1},
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  0, 60,  1'b1, STATUS_COUNTED, 8'd0, 32'd2, 1'b0},
        '{1'b0, 4'd5,  PROTO_NUM_TCP,  1, 64,  1'b1, STATUS_COUNTED, 8'd1, 32'd1, 1'b1},
        '{1'b1, 4'd6,  PROTO_NUM_UDP,  2, 70,  1'b1, STATUS_COUNTED, 8'd2, 32'd1, 1'b1},
        '{1'b0, 4'd5,  PROTO_NUM_ICMP, 3, 40,  1'b1, STATUS_COUNTED, 8'd3, 32'd1, 1'b1},
        '{1'b0, 4'd5,  PROTO_NUM_IGMP, 3, 40,  1'b1, STATUS_COUNTED, 8'd4, 32'd1, 1'b1},
        '{1'b0, 4'd5,  8'h99,          4, 34,  1'b1, STATUS_COUNTED, 8'd5, 32'd1, 1'b1},
        '{1'b0, 4'd4,  PROTO_NUM_UDP,  5, 60,  1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0},
        '{1'b0, 4'd0,  PROTO_NUM_TCP,  5, 60,  1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0},
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  5, 20,  1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0},
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  5, 37,  1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0},
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  5, 38,  1'b1, STATUS_COUNTED, 8'd6, 32'd1, 1'b1},
        '{1'b0, 4'd5,  PROTO_NUM_TCP, 15, 200, 1'b1, STATUS_COUNTED, 8'd7, 32'd1, 1'b1},
        '{1'b0, 4'd15, PROTO_NUM_UDP,  6, 78,  1'b1, STATUS_COUNTED, 8'd8, 32'd1, 1'b1},
        '{1'b0, 4'd5,  PROTO_NUM_UDP,  6, 1,   1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0},
        '{1'b1, 4'd5,  PROTO_NUM_UDP,  7, 41,  1'b1, STATUS_BAD,     8'd0, 32'd0, 1'b0}
    };

    // Random packet: mostly well-formed repeats of pooled flows, then fresh
    // flows, short packets, bad header lengths and pure noise.
    task automatic random_packet();
        int          pick, len, need;
        logic        tag;
        logic [3:0]  hl;
        logic [15:0] etype;
        flow_tuple_t t;
        pick = $urandom_range(0, 99);
        tag = ($urandom_range(0, 3) == 0);
        etype = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0800;
        hl = 4'($urandom_range(5, 8));
        t = pool[$urandom_range(0, 15)];
        if (pick >= 70 && pick < 80) begin
            case ($urandom_range(0, 4))
                0: t = random_tuple(PROTO_NUM_UDP);
                1: t = random_tuple(PROTO_NUM_TCP);
                2: t = random_tuple(PROTO_NUM_ICMP);
                3: t = random_tuple(PROTO_NUM_IGMP);
                default: t = random_tuple(8'($urandom));
            endcase
        end
        if (pick >= 88 && pick < 94) hl = 4'($urandom_range(0, 4));
        need = min_length(tag, int'(hl), t.proto);
        len = need + $urandom_range(0, 30);
        if (pick >= 80 && pick < 88) len = $urandom_range(1, need - 1);
        if ($urandom_range(0, 19) == 0) hl = 4'($urandom_range(9, 15));
        if (hl > 8) len = min_length(tag, int'(hl), t.proto) + $urandom_range(0, 60);
        build_packet(tag, etype, hl, t, len);
        if (pick >= 94) begin
            for (int i = 0; i < pkt_bytes.size(); i++) pkt_bytes[i] = 8'($urandom);
        end
        send_packet();
    endtask

    // Result side: check each accepted beat, then stall for a drawn number
    // of cycles; some stretches never stall.
    int   rx_stall = 0;
    logic rx_calm = 1'b0;

    always @(posedge aclk) begin
        flow_report_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.sip    = m_axis_tdata[31:0];
            got.dip    = m_axis_tdata[63:32];
            got.sport  = m_axis_tdata[79:64];
            got.dport  = m_axis_tdata[95:80];
            got.kind   = m_axis_tdata[98:96];
            got.slot   = m_axis_tdata[106:99];
            got.total  = m_axis_tdata[138:107];
            got.first  = m_axis_tdata[139];
            got.status = m_axis_tdata[141:140];
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(got.sip), 64'h0);
            end else begin
                want = pending_reports.pop_front();
                if (got.sip != want.sip)
                    report_mismatch("source_ip", 64'(got.sip), 64'(want.sip));
                if (got.dip != want.dip)
                    report_mismatch("dest_ip", 64'(got.dip), 64'(want.dip));
                if (got.sport != want.sport)
                    report_mismatch("source_port", 64'(got.sport), 64'(want.sport));
                if (got.dport != want.dport)
                    report_mismatch("dest_port", 64'(got.dport), 64'(want.dport));
                if (got.kind != want.kind)
                    report_mismatch("protocol", 64'(got.kind), 64'(want.kind));
                if (got.slot != want.slot)
                    report_mismatch("flow_slot", 64'(got.slot), 64'(want.slot));
                if (got.total != want.total)
                    report_mismatch("packet_total", 64'(got.total), 64'(want.total));
                if (got.first != want.first)
                    report_mismatch("first_of_flow", 64'(got.first), 64'(want.first));
                if (got.status != want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
            end
            if ($urandom_range(0, 7) == 0) rx_calm = ~rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, 15);
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn;
        end
    end

    initial begin
        flow_tuple_t t;
        clear_parser();
        flows_used = 0;
        for (int i = 0; i < 16; i++) begin
            case (i % 5)
                0: pool[i] = random_tuple(PROTO_NUM_UDP);
                1: pool[i] = random_tuple(PROTO_NUM_TCP);
                2: pool[i] = random_tuple(PROTO_NUM_ICMP);
                3: pool[i] = random_tuple(PROTO_NUM_IGMP);
                default: pool[i] = random_tuple(8'($urandom));
            endcase
        end
        // all-ones addresses and ports as the upper extreme
        pool[15] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, PROTO_NUM_TCP};
        pool[5].sip = '0; pool[5].dip = '0; pool[5].sport = '0; pool[5].dport = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[n]) begin
            t = pool[rows[n].flow];
            t.proto = rows[n].proto;
            build_packet(rows[n].tag, 16'h0800, rows[n].hl, t, rows[n].len);
            send_packet();
            // cross-check the typed-in outcome against the model
            if (rows[n].typed && (last_report.status != rows[n].status
                    || last_report.slot != rows[n].slot || last_report.total != rows[n].total
                    || last_report.first != rows[n].first))
                report_mismatch($sformatf("directed packet %0d outcome", n),
                                64'({last_report.status, last_report.slot,
                                     last_report.total}),
                                64'({rows[n].status, rows[n].slot, rows[n].total}));
        end

        while (bytes_sent < 1950) random_packet();

        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
        if (error_count == 0) begin
            $display("packet_flow_tuple_counter_core: match");
        end else begin
            $display("packet_flow_tuple_counter_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("packet_flow_tuple_counter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/pftc_pkg.sv
rtl/core/pftc_parser.sv
rtl/core/packet_flow_tuple_counter_core.sv
rtl/core/pftc_checker.sv
test/packet_flow_tuple_counter_core_tb.sv
